// ===== sv/twca_pkg.sv =====
// ---------------------------------------------------------------------------
// twca_pkg
// Shared types and constants of the time-window channel averager.
// ---------------------------------------------------------------------------
package twca_pkg;

   localparam int CHANNELS_DEF    = 16;
   localparam int COUNT_WIDTH_DEF = 16;
   localparam int SUM_WIDTH       = 48;
   localparam int TIME_WIDTH      = 63;
   localparam int WEND_WIDTH      = 64;
   localparam int PERIOD_WIDTH    = 32;
   localparam int NCH_WIDTH       = 5;
   localparam int CSR_ADDR_WIDTH  = 3;
   localparam int CHIDX_WIDTH     = 4;

   localparam logic [CSR_ADDR_WIDTH-1:0] ADDR_PERIOD   = 3'd0;
   localparam logic [CSR_ADDR_WIDTH-1:0] ADDR_CHANNELS = 3'd4;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_FLUSH  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DIV_START,
      ST_DIV_RUN,
      ST_EMIT,
      ST_ADVANCE,
      ST_CEIL_START,
      ST_CEIL_RUN,
      ST_CEIL_SET,
      ST_CLEAR,
      ST_ACCUM
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic latch_req;    // capture input beat
      logic scan_step;    // step scan of counts
      logic scan_start;   // reset channel index
      logic div_start;    // start average division
      logic div_step;     // one division step
      logic emit_load;    // load output register
      logic ch_next;      // advance channel index
      logic advance;      // advance window end
      logic ceil_start;   // start ceiling division
      logic ceil_step;    // step ceiling division
      logic ceil_set;     // window end := ceil(time)
      logic clear_step;   // clear step (clears the whole bank)
      logic accum;        // accumulate latched value
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic is_flush;
      logic started;
      logic window_hit;   // first of sample, time >= end
      logic time_beyond;  // time > end
      logic any_data;
      logic ch_last;      // index at last channel in use
      logic div_done;
      logic ceil_done;
      logic out_busy;     // output register occupied and not drained
   } status_type;

endpackage

// ===== sv/twca_if.sv =====
// ---------------------------------------------------------------------------
// twca_req_if / twca_rsp_if
// Valid/ready channels of the averager.
// ---------------------------------------------------------------------------
interface twca_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [62:0] sample_time;
   logic        first_of_sample;
   logic [3:0]  channel;
   logic signed [31:0] value;
   logic        value_valid;
   modport source (output valid, opcode, sample_time, first_of_sample, channel,
                   value, value_valid, input ready);
   modport sink (input valid, opcode, sample_time, first_of_sample, channel,
                 value, value_valid, output ready);
endinterface

interface twca_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  out_channel;
   logic signed [31:0] average;
   logic        average_valid;
   logic [62:0] mid_time;
   logic        last;
   modport source (output valid, out_channel, average, average_valid, mid_time,
                   last, input ready);
   modport sink (input valid, out_channel, average, average_valid, mid_time,
                 last, output ready);
endinterface

// ===== sv/twca_ctrl.sv =====
// ---------------------------------------------------------------------------
// twca_ctrl
// Sequencer: window check, emission walk, window advance, clear, accumulate.
// ---------------------------------------------------------------------------
module twca_ctrl
   import twca_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type stat,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch_req  = 1'b1;
               cmd.scan_start = 1'b1;
               state_in       = ST_SCAN;
            end
         end
         // on flush walk the counts to learn whether any channel has data; else check the window
         ST_SCAN: begin
            if (stat.is_flush) begin
               if (!stat.ch_last) begin
                  cmd.scan_step = 1'b1;
               end else begin
                  cmd.scan_step  = 1'b1;
                  cmd.scan_start = 1'b1;
                  if (!stat.started) begin
                     state_in = ST_CLEAR;
                  end else if (stat.any_data) begin
                     state_in = ST_DIV_START;
                  end else begin
                     state_in = ST_ADVANCE;
                  end
               end
            end else begin
               cmd.scan_start = 1'b1;
               if (!stat.window_hit) begin
                  state_in = ST_ACCUM;
               end else if (stat.started) begin
                  state_in = ST_DIV_START;
               end else begin
                  state_in = ST_CEIL_START;
               end
            end
         end
         ST_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_RUN;
         end
         ST_DIV_RUN: begin
            if (stat.div_done) begin
               state_in = ST_EMIT;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_EMIT: begin
            if (!stat.out_busy) begin
               cmd.emit_load = 1'b1;
               if (stat.ch_last) begin
                  state_in = ST_ADVANCE;
               end else begin
                  cmd.ch_next = 1'b1;
                  state_in    = ST_DIV_START;
               end
            end
         end
         ST_ADVANCE: begin
            cmd.advance    = 1'b1;
            cmd.scan_start = 1'b1;
            if (!stat.is_flush) begin
               state_in = ST_CEIL_START;
            end else begin
               state_in = ST_CLEAR;
            end
         end
         // time beyond end (after advance) or first start: ceil to period
         ST_CEIL_START: begin
            if (stat.started && !stat.time_beyond) begin
               state_in = ST_CLEAR;
            end else begin
               cmd.ceil_start = 1'b1;
               state_in       = ST_CEIL_RUN;
            end
         end
         ST_CEIL_RUN: begin
            if (stat.ceil_done) begin
               state_in = ST_CEIL_SET;
            end else begin
               cmd.ceil_step = 1'b1;
            end
         end
         ST_CEIL_SET: begin
            cmd.ceil_set = 1'b1;
            state_in     = ST_CLEAR;
         end
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.ch_last) begin
               cmd.scan_start = 1'b1;
               state_in = stat.is_flush ? ST_IDLE : ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            cmd.accum = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== sv/twca_datapath.sv =====
// ---------------------------------------------------------------------------
// twca_datapath
// Channel sums and counts, window end, shared dividers, output register.
// ---------------------------------------------------------------------------
module twca_datapath
   import twca_pkg::*;
#(
   parameter int CHANNELS    = CHANNELS_DEF,
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [PERIOD_WIDTH-1:0] period,
   input  logic [NCH_WIDTH-1:0]    nch_cfg,
   twca_req_if.sink    req,
   twca_rsp_if.source  rsp,
   input  cmd_type     cmd,
   output status_type  stat
);

   localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int NW = $clog2(CHANNELS + 1);
   localparam int DW = SUM_WIDTH;     // average divider width
   localparam int CW = TIME_WIDTH;    // ceiling divider width
   localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
   localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

   // latched input beat
   logic                   op_ff;
   logic [TIME_WIDTH-1:0]  time_ff;
   logic                   first_ff;
   logic [CHIDX_WIDTH-1:0] ch_ff;
   logic signed [31:0]     val_ff;
   logic                   vv_ff;

   logic signed [SUM_WIDTH-1:0]   sums_ff [CHANNELS];
   logic [COUNT_WIDTH-1:0]        cnts_ff [CHANNELS];
   logic [WEND_WIDTH-1:0]         wend_ff;
   logic [IW-1:0]                 idx_ff;
   logic                          any_ff;

   // effective config
   logic [PERIOD_WIDTH-1:0] p_eff;
   logic [NW-1:0]           n_eff;
   assign p_eff = (period == '0) ? PERIOD_WIDTH'(1) : period;
   always_comb begin
      if (nch_cfg == '0) begin
         n_eff = NW'(1);
      end else if (32'(nch_cfg) > CHANNELS) begin
         n_eff = NW'(CHANNELS);
      end else begin
         n_eff = NW'(nch_cfg);
      end
   end

   logic idx_last;
   assign idx_last = ({1'b0, idx_ff} + (IW+1)'(1)) >= (IW+1)'(n_eff);

   // capture request
   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         op_ff    <= req.opcode;
         time_ff  <= req.sample_time;
         first_ff <= req.first_of_sample;
         ch_ff    <= req.channel;
         val_ff   <= req.value;
         vv_ff    <= req.value_valid;
      end
   end

   // channel index and scan of counts
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         any_ff <= 1'b0;
      end else begin
         if (cmd.scan_start) begin
            idx_ff <= '0;
            any_ff <= 1'b0;
         end else if (cmd.scan_step || cmd.ch_next || cmd.clear_step) begin
            idx_ff <= idx_ff + IW'(1);
         end
         if (cmd.scan_step && !cmd.scan_start && cnts_ff[idx_ff] != '0) begin
            any_ff <= 1'b1;
         end
      end
   end

   // restoring divider: |sum| / count, one quotient bit per cycle
   logic [DW-1:0]          dq_ff;   // dividend shifting into quotient
   logic [COUNT_WIDTH:0]   dr_ff;   // partial remainder
   logic [COUNT_WIDTH-1:0] dd_ff;   // divisor
   logic                   dneg_ff;
   logic [$clog2(DW+1)-1:0] dcnt_ff;
   logic                   dok_ff;
   logic [COUNT_WIDTH:0]   dr_sh;
   logic signed [SUM_WIDTH-1:0] cur_sum;
   assign cur_sum = sums_ff[idx_ff];
   assign dr_sh   = {dr_ff[COUNT_WIDTH-1:0], dq_ff[DW-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         dcnt_ff <= '0;
      end else if (cmd.div_start) begin
         dcnt_ff <= ($clog2(DW+1))'(DW);
      end else if (cmd.div_step) begin
         dcnt_ff <= dcnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         dq_ff   <= cur_sum[SUM_WIDTH-1] ? DW'(-cur_sum) : DW'(cur_sum);
         dr_ff   <= '0;
         dd_ff   <= cnts_ff[idx_ff];
         dneg_ff <= cur_sum[SUM_WIDTH-1];
         dok_ff  <= cnts_ff[idx_ff] != '0;
      end else if (cmd.div_step) begin
         if (dr_sh >= {1'b0, dd_ff}) begin
            dr_ff <= dr_sh - {1'b0, dd_ff};
            dq_ff <= {dq_ff[DW-2:0], 1'b1};
         end else begin
            dr_ff <= dr_sh;
            dq_ff <= {dq_ff[DW-2:0], 1'b0};
         end
      end
   end

   // signed, saturated average
   logic signed [DW:0]  avg_w;
   logic signed [31:0]  avg_sat;
   assign avg_w = dneg_ff ? -$signed({1'b0, dq_ff}) : $signed({1'b0, dq_ff});
   always_comb begin
      if (!dok_ff) begin
         avg_sat = '0;
      end else if (avg_w > (DW+1)'(32'sh7FFFFFFF)) begin
         avg_sat = 32'sh7FFFFFFF;
      end else if (avg_w < -$signed((DW+1)'(33'h80000000))) begin
         avg_sat = 32'sh80000000;
      end else begin
         avg_sat = avg_w[31:0];
      end
   end

   // mid time
   logic [WEND_WIDTH-1:0] half;
   logic [WEND_WIDTH-1:0] mid;
   assign half = WEND_WIDTH'(p_eff >> 1);
   assign mid  = (wend_ff >= half) ? wend_ff - half : '0;

   // ceiling divider: time / period, restoring, one bit per cycle
   logic [CW-1:0]           cq_ff;
   logic [PERIOD_WIDTH:0]   cr_ff;
   logic [$clog2(CW+1)-1:0] ccnt_ff;
   logic [PERIOD_WIDTH:0]   cr_sh;
   assign cr_sh = {cr_ff[PERIOD_WIDTH-1:0], cq_ff[CW-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         ccnt_ff <= '0;
      end else if (cmd.ceil_start) begin
         ccnt_ff <= ($clog2(CW+1))'(CW);
      end else if (cmd.ceil_step) begin
         ccnt_ff <= ccnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ceil_start) begin
         cq_ff <= time_ff;
         cr_ff <= '0;
      end else if (cmd.ceil_step) begin
         if (cr_sh >= {1'b0, p_eff}) begin
            cr_ff <= cr_sh - {1'b0, p_eff};
            cq_ff <= {cq_ff[CW-2:0], 1'b1};
         end else begin
            cr_ff <= cr_sh;
            cq_ff <= {cq_ff[CW-2:0], 1'b0};
         end
      end
   end

   // ceil result: time plus what is left to the next period boundary
   logic [WEND_WIDTH-1:0] ceil_val;
   assign ceil_val = (cr_ff != '0)
                     ? WEND_WIDTH'(time_ff) + WEND_WIDTH'(p_eff) - WEND_WIDTH'(cr_ff)
                     : WEND_WIDTH'(time_ff);

   // window end
   logic [WEND_WIDTH:0] wend_add;
   assign wend_add = {1'b0, wend_ff} + (WEND_WIDTH+1)'(p_eff);
   always_ff @(posedge clock) begin
      if (reset) begin
         wend_ff <= '0;
      end else if (cmd.advance) begin
         wend_ff <= wend_add[WEND_WIDTH] ? '1 : wend_add[WEND_WIDTH-1:0];
      end else if (cmd.ceil_set) begin
         wend_ff <= ceil_val;
      end
   end

   // sums and counts: clear walk and accumulate
   logic signed [SUM_WIDTH:0] acc_sum;
   logic                      acc_en;
   assign acc_sum = {sums_ff[ch_ff[IW-1:0]][SUM_WIDTH-1], sums_ff[ch_ff[IW-1:0]]}
                    + (SUM_WIDTH+1)'(val_ff);
   assign acc_en  = cmd.accum && vv_ff && ({1'b0, ch_ff} < (CHIDX_WIDTH+1)'(n_eff))
                    && (cnts_ff[ch_ff[IW-1:0]] != '1);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            sums_ff[i] <= '0;
            cnts_ff[i] <= '0;
         end
      end else if (cmd.clear_step) begin
         // clear the whole bank on every step
         for (int i = 0; i < CHANNELS; i++) begin
            sums_ff[i] <= '0;
            cnts_ff[i] <= '0;
         end
      end else if (acc_en) begin
         if (acc_sum > (SUM_WIDTH+1)'(SUM_MAX)) begin
            sums_ff[ch_ff[IW-1:0]] <= SUM_MAX;
         end else if (acc_sum < (SUM_WIDTH+1)'(SUM_MIN)) begin
            sums_ff[ch_ff[IW-1:0]] <= SUM_MIN;
         end else begin
            sums_ff[ch_ff[IW-1:0]] <= acc_sum[SUM_WIDTH-1:0];
         end
         cnts_ff[ch_ff[IW-1:0]] <= cnts_ff[ch_ff[IW-1:0]] + 1'b1;
      end
   end

   // output register
   logic rv_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else if (cmd.emit_load) begin
         rv_ff <= 1'b1;
      end else if (rsp.ready) begin
         rv_ff <= 1'b0;
      end
   end
   always_ff @(posedge clock) begin
      if (cmd.emit_load) begin
         rsp.out_channel   <= CHIDX_WIDTH'(idx_ff);
         rsp.average       <= avg_sat;
         rsp.average_valid <= dok_ff;
         rsp.mid_time      <= mid[TIME_WIDTH-1:0];
         rsp.last          <= idx_last;
      end
   end
   assign rsp.valid = rv_ff;

   // status; the channel under the scan index counts towards any data
   assign stat.is_flush    = op_ff == OP_FLUSH;
   assign stat.started     = wend_ff != '0;
   assign stat.window_hit  = first_ff && (WEND_WIDTH'(time_ff) >= wend_ff);
   assign stat.time_beyond = WEND_WIDTH'(time_ff) > wend_ff;
   assign stat.any_data    = any_ff || (cnts_ff[idx_ff] != '0);
   assign stat.ch_last     = idx_last;
   assign stat.div_done    = dcnt_ff == '0;
   assign stat.ceil_done   = ccnt_ff == '0;
   assign stat.out_busy    = rv_ff && !rsp.ready;

endmodule

// ===== sv/time_window_channel_averager.sv =====
// ---------------------------------------------------------------------------
// time_window_channel_averager
// Per-channel windowed averages of time-tagged samples, APB register port.
// ---------------------------------------------------------------------------
// A sample element passes idle, scan and accumulate; a window hit adds the
// emission walk and a clear, and the first start or a time jump adds the ceiling division.
// Each channel in use is emitted through the bit-serial divider, and an
// emission waits while the one-beat output register is not drained.
// Flush scans the counts of the channels in use before any emission.
// Synchronous reset clears window end, sums and counts and loads the registers with their defaults.
module time_window_channel_averager
   import twca_pkg::*;
#(
   parameter int CHANNELS    = CHANNELS_DEF,
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic clock,
   input  logic reset,
   twca_req_if.sink   req,
   twca_rsp_if.source rsp,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);

   logic [PERIOD_WIDTH-1:0] period_ff;
   logic [NCH_WIDTH-1:0]    nch_ff;
   logic                    wr;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_WIDTH'(1000000);
         nch_ff    <= NCH_WIDTH'(16);
      end else if (wr) begin
         case (csr_paddr)
            ADDR_PERIOD:   period_ff <= csr_pwdata;
            ADDR_CHANNELS: nch_ff    <= csr_pwdata[NCH_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // register reads
   always_comb begin
      case (csr_paddr)
         ADDR_PERIOD:   csr_prdata = period_ff;
         ADDR_CHANNELS: csr_prdata = 32'(nch_ff);
         default:       csr_prdata = '0;
      endcase
   end

   cmd_type    cmd;
   status_type stat;

   twca_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   twca_datapath #(
      .CHANNELS    (CHANNELS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_dp (
      .clock   (clock),
      .reset   (reset),
      .period  (period_ff),
      .nch_cfg (nch_ff),
      .req     (req),
      .rsp     (rsp),
      .cmd     (cmd),
      .stat    (stat)
   );

   // output register never overwritten while a beat waits
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |-> !cmd.emit_load)
      else $error("result overwritten");

   // no new beat taken while a result load or an accumulate is in progress
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> !cmd.emit_load && !cmd.accum)
      else $error("accept during work");

   // division never loaded and stepped together
   a_div_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.div_start && cmd.div_step))
      else $error("divider conflict");

endmodule
